// ===== sv/mwht_pkg.sv =====
package mwht_pkg;

   localparam int SLOTS     = 256;
   localparam int WAYS      = 8;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int WAY_W     = $clog2(WAYS);
   localparam int WCNT_W    = WAY_W + 1;
   localparam int ADDR_W    = SLOT_W + WAY_W;
   localparam int MOD_W     = SLOT_W + 1;
   localparam int REM_W     = MOD_W + 1;
   localparam int CFG_W     = 9;
   localparam int KEY_W     = 64;
   localparam int CNT_W     = 12;
   localparam int ST_W      = 3;
   localparam int OP_W      = 2;
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = KEY_W / MOD_BITS;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
   localparam logic [OP_W-1:0] OP_GET  = 2'd1;
   localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [ST_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [ST_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [ST_W-1:0] ST_MISS     = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic hash_load;
      logic way_inc;
      logic decide;
      logic finish_end;
      logic rsp_load;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic way_end;
      logic op_none;
      logic proceed;
   } dp_sts_type;

endpackage

// ===== sv/multi_way_hash_table_engine_top.sv =====
// key/value table engine: put, get and delete of 64-bit keys over up to eight
// ways of 256 slots, probing the home slot and its neighbour in each way.
// request channel (req_*): opcode, key and value, taken when req_valid and
// req_ready are both high. one response per request on rsp_* with status,
// old or found value and the entry count after the operation.
// csr channel: writes slots_in_use (hash modulus), always ready; write only
// while no request is in flight.
// an item runs through the key remainder (four bits a step), the forming of the
// slot pair and its probe steps (registered memory read, then compare), then loads
// the response. there is one probe step per way visited, plus a last one when no
// way settles the item; after the response is loaded the engine returns to idle,
// where the next request is taken.
// after reset the valid rows are swept clear, one slot row a cycle, over all 256
// slot rows; no request is taken meanwhile.
// the response sits in an output register: a new request is taken while it
// waits, but the finished item holds until rsp_ready frees that register.
module multi_way_hash_table_engine_top import mwht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [KEY_W-1:0]  req_lookup_key,
   input  logic [KEY_W-1:0]  req_new_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ST_W-1:0]   rsp_status,
   output logic [KEY_W-1:0]  rsp_value_out,
   output logic [CNT_W-1:0]  rsp_entry_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_slots_in_use
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   mwht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mwht_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_lookup_key   (req_lookup_key),
      .req_new_value    (req_new_value),
      .csr_we           (csr_valid & csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_entry_count  (rsp_entry_count)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_MISS ||
                     rsp_status == ST_FULL)) |-> (rsp_value_out == '0))
      else $error("value returned with a status that carries none");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(SLOTS * WAYS)))
      else $error("entry count beyond table size");

endmodule

// ===== sv/mwht_datapath.sv =====
module mwht_datapath import mwht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [KEY_W-1:0]  req_lookup_key,
   input  logic [KEY_W-1:0]  req_new_value,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_slots_in_use,
   output logic [ST_W-1:0]   rsp_status,
   output logic [KEY_W-1:0]  rsp_value_out,
   output logic [CNT_W-1:0]  rsp_entry_count
);

   localparam logic [3:0] ACT_NEXT  = 4'd0;
   localparam logic [3:0] ACT_INS_H = 4'd1;
   localparam logic [3:0] ACT_INS_N = 4'd2;
   localparam logic [3:0] ACT_REP_H = 4'd3;
   localparam logic [3:0] ACT_REP_N = 4'd4;
   localparam logic [3:0] ACT_HIT_H = 4'd5;
   localparam logic [3:0] ACT_HIT_N = 4'd6;
   localparam logic [3:0] ACT_NEW   = 4'd7;
   localparam logic [3:0] ACT_FULL  = 4'd8;
   localparam logic [3:0] ACT_MISS  = 4'd9;

   logic [OP_W-1:0]   op_ff;
   logic [KEY_W-1:0]  key_ff, val_ff, sh_ff, sh_in;
   logic [MOD_W-1:0]  rem_ff, rem_in, m;
   logic [REM_W-1:0]  t;
   logic [STEP_W-1:0] step_ff;
   logic [SLOT_W-1:0] h_ff, n_ff, nxt, clr_ff;
   logic [MOD_W:0]    rem_p1;
   logic [WCNT_W-1:0] way_ff, active_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CFG_W-1:0]  slots_ff;
   logic [ST_W-1:0]   res_st, res_st_ff;
   logic [KEY_W-1:0]  res_val, res_val_ff;
   logic [3:0]        act;

   logic [KEY_W-1:0]  kmem [SLOTS*WAYS];
   logic [KEY_W-1:0]  dmem [SLOTS*WAYS];
   logic [WAYS-1:0]   vmem [SLOTS];
   logic [KEY_W-1:0]  kh_ff, kn_ff, dh_ff, dn_ff;
   logic [WAYS-1:0]   vh_ff, vn_ff, bit_w, bit_a;
   logic [ADDR_W-1:0] addr_h, addr_n, kv_addr;
   logic              kv_we, v_we, cnt_inc, cnt_dec;
   logic [SLOT_W-1:0] v_addr;
   logic [WAYS-1:0]   v_data;
   logic              vh, vn, kh_eq, kn_eq;

   // effective modulus: zero acts as one, above the way size clamps
   assign m = (slots_ff == '0) ? MOD_W'(1) :
              (slots_ff > CFG_W'(SLOTS)) ? MOD_W'(SLOTS) : MOD_W'(slots_ff);

   // restoring remainder, four key bits a step
   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      t      = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         t     = {rem_in, sh_in[KEY_W-1]};
         sh_in = sh_in << 1;
         if (t >= REM_W'(m)) t = t - REM_W'(m);
         rem_in = t[MOD_W-1:0];
      end
   end

   assign rem_p1 = {1'b0, rem_ff} + (MOD_W+1)'(1);
   assign nxt    = (rem_p1 == {1'b0, m}) ? '0 : rem_p1[SLOT_W-1:0];

   assign addr_h = {way_ff[WAY_W-1:0], h_ff};
   assign addr_n = {way_ff[WAY_W-1:0], n_ff};
   assign bit_w  = WAYS'(1) << way_ff[WAY_W-1:0];
   assign bit_a  = WAYS'(1) << active_ff[WAY_W-1:0];
   assign vh     = vh_ff[way_ff[WAY_W-1:0]];
   assign vn     = vn_ff[way_ff[WAY_W-1:0]];
   assign kh_eq  = (kh_ff == key_ff);
   assign kn_eq  = (kn_ff == key_ff);

   always_comb begin
      act = ACT_NEXT;
      if (cmd.finish_end) begin
         if (op_ff == OP_PUT) begin
            act = (active_ff < WCNT_W'(WAYS)) ? ACT_NEW : ACT_FULL;
         end else begin
            act = ACT_MISS;
         end
      end else if (op_ff == OP_PUT) begin
         if (!vh)               act = ACT_INS_H;
         else if (kh_eq)        act = ACT_REP_H;
         else if (vn && kn_eq)  act = ACT_REP_N;
         else if (!vn)          act = ACT_INS_N;
      end else if (vh) begin
         if (kh_eq)             act = ACT_HIT_H;
         else if (vn && kn_eq)  act = ACT_HIT_N;
      end
   end

   always_comb begin
      kv_we   = 1'b0;
      kv_addr = addr_h;
      v_we    = 1'b0;
      v_addr  = h_ff;
      v_data  = vh_ff;
      cnt_inc = 1'b0;
      cnt_dec = 1'b0;
      res_st  = ST_MISS;
      res_val = '0;
      if (cmd.clear_step) begin
         v_we   = 1'b1;
         v_addr = clr_ff;
         v_data = '0;
      end else if (cmd.decide || cmd.finish_end) begin
         unique case (act)
            ACT_INS_H: begin
               kv_we = 1'b1; v_we = 1'b1; v_data = vh_ff | bit_w;
               cnt_inc = 1'b1; res_st = ST_INSERTED;
            end
            ACT_INS_N: begin
               kv_we = 1'b1; kv_addr = addr_n; v_we = 1'b1; v_addr = n_ff;
               v_data = vn_ff | bit_w; cnt_inc = 1'b1; res_st = ST_INSERTED;
            end
            ACT_REP_H: begin
               kv_we = 1'b1; res_st = ST_REPLACED; res_val = dh_ff;
            end
            ACT_REP_N: begin
               kv_we = 1'b1; kv_addr = addr_n; res_st = ST_REPLACED; res_val = dn_ff;
            end
            ACT_HIT_H: begin
               res_st = ST_FOUND;
               if (op_ff == OP_GET) begin
                  res_val = dh_ff;
               end else begin
                  v_we = 1'b1; v_data = vh_ff & ~bit_w; cnt_dec = 1'b1;
               end
            end
            ACT_HIT_N: begin
               res_st = ST_FOUND;
               if (op_ff == OP_GET) begin
                  res_val = dn_ff;
               end else begin
                  v_we = 1'b1; v_addr = n_ff; v_data = vn_ff & ~bit_w; cnt_dec = 1'b1;
               end
            end
            ACT_NEW: begin
               kv_we = 1'b1; kv_addr = {active_ff[WAY_W-1:0], h_ff};
               v_we = 1'b1; v_data = vh_ff | bit_a; cnt_inc = 1'b1;
               res_st = ST_INSERTED;
            end
            ACT_FULL: res_st = ST_FULL;
            default:  res_st = ST_MISS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kmem[kv_addr] <= key_ff;
         dmem[kv_addr] <= val_ff;
      end
      kh_ff <= kmem[addr_h];
      kn_ff <= kmem[addr_n];
      dh_ff <= dmem[addr_h];
      dn_ff <= dmem[addr_n];
   end

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_addr] <= v_data;
      vh_ff <= vmem[h_ff];
      vn_ff <= vmem[n_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= WCNT_W'(1);
         count_ff  <= '0;
         clr_ff    <= '0;
         slots_ff  <= CFG_W'(SLOTS);
         step_ff   <= '0;
         way_ff    <= '0;
      end else begin
         if (csr_we) slots_ff <= csr_slots_in_use;
         if (cmd.clear_step) clr_ff <= clr_ff + SLOT_W'(1);
         if (cmd.load) step_ff <= '0;
         else if (cmd.mod_step) step_ff <= step_ff + STEP_W'(1);
         if (cmd.hash_load) way_ff <= '0;
         else if (cmd.way_inc) way_ff <= way_ff + WCNT_W'(1);
         if (cmd.finish_end && act == ACT_NEW) active_ff <= active_ff + WCNT_W'(1);
         if (cnt_inc) count_ff <= count_ff + CNT_W'(1);
         else if (cnt_dec && count_ff != '0) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_lookup_key;
         val_ff <= req_new_value;
         sh_ff  <= req_lookup_key;
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         sh_ff  <= sh_in;
         rem_ff <= rem_in;
      end
      if (cmd.hash_load) begin
         h_ff <= rem_ff[SLOT_W-1:0];
         n_ff <= nxt;
      end
      if (cmd.decide || cmd.finish_end) begin
         res_st_ff  <= res_st;
         res_val_ff <= res_val;
      end
      if (cmd.rsp_load) begin
         rsp_status      <= res_st_ff;
         rsp_value_out   <= res_val_ff;
         rsp_entry_count <= count_ff;
      end
   end

   assign sts.clear_done = (clr_ff == SLOT_W'(SLOTS - 1));
   assign sts.mod_done   = (step_ff == STEP_W'(MOD_STEPS - 1));
   assign sts.way_end    = (way_ff == active_ff);
   assign sts.op_none    = (op_ff == OP_NONE);
   assign sts.proceed    = (act == ACT_NEXT);

endmodule

// ===== sv/mwht_ctrl.sv =====
module mwht_ctrl import mwht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_HASH  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_CHK   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) state_in = S_HASH;
         end
         S_HASH: begin
            cmd.hash_load = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: state_in = S_CHK;
         S_CHK: begin
            if (sts.op_none || sts.way_end) begin
               cmd.finish_end = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd.decide = 1'b1;
               if (sts.proceed) begin
                  cmd.way_inc = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
